// ===== hw/rtl/p2d_pkg.sv =====
// Shared types, constants and helpers for the 2-D max/average pooling block.
// No dependencies; used by the channel interfaces, the top-level module and the bench.
`default_nettype none

package p2d_pkg;

  // Store geometry and window limit
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_POOL   = 8;

  localparam int STORE_DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int COL_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WIN_W       = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int POS_OUT_W  = 12;
  localparam int POOL_W     = 4;
  localparam int STRIDE_W   = 4;
  localparam int DIM_W      = 7;
  localparam int CHCNT_W    = 9;
  localparam int CHPOS_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Window sum and serial divider
  localparam int SUM_W  = SAMPLE_W + 2 * WIN_W;
  localparam int DIV_W  = 2 * POOL_W;
  localparam int DCNT_W = $clog2(SUM_W);

  // Register reset values
  localparam logic [POOL_W-1:0]    RST_WIN_SIDE  = POOL_W'(2);
  localparam logic [STRIDE_W-1:0]  RST_STRIDE    = STRIDE_W'(2);
  localparam logic [DIM_W-1:0]     RST_HEIGHT    = DIM_W'(28);
  localparam logic [DIM_W-1:0]     RST_WIDTH     = DIM_W'(28);
  localparam logic [CHCNT_W-1:0]   RST_CHANNELS  = CHCNT_W'(1);
  localparam logic                 RST_MODE      = 1'b0;

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_SIDE      = 3'd0,
    REG_STRIDE        = 3'd1,
    REG_PLANE_HEIGHT  = 3'd2,
    REG_PLANE_WIDTH   = 3'd3,
    REG_CHANNEL_COUNT = 3'd4,
    REG_POOL_MODE     = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_PREP,
    S_DIV,
    S_EMIT
  } state_t;

  function automatic logic [POOL_W-1:0] clamp_pool(input logic [POOL_W-1:0] v);
    if (v == '0) return POOL_W'(1);
    if (v > POOL_W'(MAX_POOL)) return POOL_W'(MAX_POOL);
    return v;
  endfunction

  function automatic logic [STRIDE_W-1:0] clamp_stride(input logic [STRIDE_W-1:0] v);
    if (v == '0) return STRIDE_W'(1);
    return v;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W:0]   hi);
    if (v == '0) return DIM_W'(1);
    if ({1'b0, v} > hi) return DIM_W'(hi);
    return v;
  endfunction

  function automatic logic [CHCNT_W-1:0] clamp_channels(input logic [CHCNT_W-1:0] v);
    if (v == '0) return CHCNT_W'(1);
    if (v > CHCNT_W'(256)) return CHCNT_W'(256);
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/p2d_sample_if.sv =====
// Input channel: one signed Q8.8 plane sample per transfer.
// Depends on p2d_pkg.
`default_nettype none

interface p2d_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [p2d_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/p2d_result_if.sv =====
// Result channel: pooled value, max position and plane/set end flags.
// Depends on p2d_pkg.
`default_nettype none

interface p2d_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [p2d_pkg::SAMPLE_W-1:0]  pooled_value;
  logic        [p2d_pkg::POS_OUT_W-1:0] max_position;
  logic                                 plane_done;
  logic                                 set_done;

  modport source (output valid, output pooled_value, output max_position,
                  output plane_done, output set_done, input ready);
  modport sink   (input valid, input pooled_value, input max_position,
                  input plane_done, input set_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/p2d_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on p2d_pkg.
`default_nettype none

interface p2d_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [p2d_pkg::CFG_IDX_W-1:0]       index;
  logic [p2d_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pool2d_max_average.sv =====
// Top level of the 2-D max/average pooling block: sequencer, window walker,
// serial divider and output register. Depends on p2d_pkg, p2d_*_if, p2d_ram.
//
// Samples arrive one per transfer in raster order, plane after plane, and are
// written to a 4096-entry plane RAM. A sample that closes a window starts a
// walk over the window through the RAM read port, one element per cycle, and
// no new sample is taken until the result is in the output register. In max
// mode the result goes to the output register after the walk; in average
// mode the window sum first goes through a shift-subtract divider. A
// finished result sits in an output register, so the next sample is taken
// while it waits. A write to any of the six defined configuration registers
// restarts the set at row, column and channel zero.
`default_nettype none

module pool2d_max_average (
  input  wire logic         clk,
  input  wire logic         rst_n,
  p2d_sample_if.sink        in_ch,
  p2d_result_if.source      out_ch,
  p2d_cfg_if.sink           cfg_ch
);

  localparam int ADDR_W = p2d_pkg::ADDR_W;
  localparam int SUM_W  = p2d_pkg::SUM_W;
  localparam int DIV_W  = p2d_pkg::DIV_W;
  localparam int SW     = p2d_pkg::SAMPLE_W;

  // Configuration
  logic [p2d_pkg::POOL_W-1:0]   win_side_r, win_side_nxt;
  logic [p2d_pkg::STRIDE_W-1:0] stride_r, stride_nxt;
  logic [p2d_pkg::DIM_W-1:0]    height_r, height_nxt;
  logic [p2d_pkg::DIM_W-1:0]    width_r, width_nxt;
  logic [p2d_pkg::CHCNT_W-1:0]  chans_r, chans_nxt;
  logic                         mode_r, mode_nxt;

  // Position tracking
  logic [p2d_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [p2d_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [p2d_pkg::CHPOS_W-1:0]  chan_r, chan_nxt;
  logic [ADDR_W-1:0]            idx_r, idx_nxt;
  logic [p2d_pkg::STRIDE_W-1:0] rph_r, rph_nxt;
  logic [p2d_pkg::STRIDE_W-1:0] cph_r, cph_nxt;

  // Sequencer and datapath
  p2d_pkg::state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]            addr_r, addr_nxt;
  logic [p2d_pkg::WIN_W-1:0]    wi_r, wi_nxt;
  logic [p2d_pkg::WIN_W-1:0]    wj_r, wj_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [ADDR_W-1:0]            rd_pos_r, rd_pos_nxt;
  logic                         first_r, first_nxt;
  logic signed [SUM_W-1:0]      acc_r, acc_nxt;
  logic [ADDR_W-1:0]            pos_r, pos_nxt;
  logic                         pdone_r, pdone_nxt;
  logic                         sdone_r, sdone_nxt;
  logic                         neg_r, neg_nxt;
  logic [SUM_W-1:0]             quot_r, quot_nxt;
  logic [DIV_W-1:0]             rem_r, rem_nxt;
  logic [p2d_pkg::DCNT_W-1:0]   dcnt_r, dcnt_nxt;

  // Output register
  logic                         out_vld_r, out_vld_nxt;
  logic signed [SW-1:0]         out_val_r, out_val_nxt;
  logic [p2d_pkg::POS_OUT_W-1:0] out_pos_r, out_pos_nxt;
  logic                         out_pd_r, out_pd_nxt;
  logic                         out_sd_r, out_sd_nxt;

  // Combinational helpers
  logic [p2d_pkg::POOL_W-1:0]   ps_c;
  logic [p2d_pkg::POOL_W-1:0]   ps_m1;
  logic [p2d_pkg::STRIDE_W-1:0] st_c;
  logic [p2d_pkg::DIM_W-1:0]    h_c;
  logic [p2d_pkg::DIM_W-1:0]    w_c;
  logic [p2d_pkg::CHCNT_W-1:0]  ch_c;
  logic [DIV_W-1:0]             dvs;
  logic [ADDR_W-1:0]            base_off;
  logic                         in_xfer;
  logic                         cfg_xfer;
  logic                         restart;
  logic [p2d_pkg::DIM_W-1:0]    nc;
  logic [p2d_pkg::DIM_W-1:0]    nr;
  logic [p2d_pkg::CHCNT_W-1:0]  nch;
  logic                         close_r;
  logic                         close_c;
  logic                         last_iss;
  logic signed [SUM_W-1:0]      rd_ext;
  logic [DIV_W-1:0]             sh;
  logic                         geq;
  logic [SW-1:0]                ram_rdata;
  logic                         ram_we;
  logic                         out_load;

  p2d_ram #(
    .WIDTH (SW),
    .DEPTH (p2d_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (in_ch.sample),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign ps_c     = p2d_pkg::clamp_pool(win_side_r);
  assign ps_m1    = ps_c - p2d_pkg::POOL_W'(1);
  assign st_c     = p2d_pkg::clamp_stride(stride_r);
  assign h_c      = p2d_pkg::clamp_dim(height_r, (p2d_pkg::DIM_W+1)'(p2d_pkg::MAX_HEIGHT));
  assign w_c      = p2d_pkg::clamp_dim(width_r, (p2d_pkg::DIM_W+1)'(p2d_pkg::MAX_WIDTH));
  assign ch_c     = p2d_pkg::clamp_channels(chans_r);
  assign dvs      = DIV_W'(ps_c) * DIV_W'(ps_c);
  assign base_off = ADDR_W'(ps_m1) * (ADDR_W'(w_c) + ADDR_W'(1));

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready         = (state_r == p2d_pkg::S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_vld_r;
  assign out_ch.pooled_value = out_val_r;
  assign out_ch.max_position = out_pos_r;
  assign out_ch.plane_done   = out_pd_r;
  assign out_ch.set_done     = out_sd_r;

  assign nc  = p2d_pkg::DIM_W'(col_r) + p2d_pkg::DIM_W'(1);
  assign nr  = p2d_pkg::DIM_W'(row_r) + p2d_pkg::DIM_W'(1);
  assign nch = p2d_pkg::CHCNT_W'(chan_r) + p2d_pkg::CHCNT_W'(1);

  assign close_r = (p2d_pkg::DIM_W'(ps_c) <= h_c)
                && (p2d_pkg::DIM_W'(row_r) >= p2d_pkg::DIM_W'(ps_m1))
                && (rph_r == '0);
  assign close_c = (p2d_pkg::DIM_W'(ps_c) <= w_c)
                && (p2d_pkg::DIM_W'(col_r) >= p2d_pkg::DIM_W'(ps_m1))
                && (cph_r == '0);

  assign last_iss = (wi_r == p2d_pkg::WIN_W'(ps_m1)) && (wj_r == p2d_pkg::WIN_W'(ps_m1));
  assign rd_ext   = SUM_W'($signed(ram_rdata));
  assign sh       = {rem_r[DIV_W-2:0], quot_r[SUM_W-1]};
  assign geq      = (sh >= dvs);

  always_comb begin
    state_nxt     = state_r;
    win_side_nxt  = win_side_r;
    stride_nxt    = stride_r;
    height_nxt    = height_r;
    width_nxt     = width_r;
    chans_nxt     = chans_r;
    mode_nxt      = mode_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    chan_nxt      = chan_r;
    idx_nxt       = idx_r;
    rph_nxt       = rph_r;
    cph_nxt       = cph_r;
    addr_nxt      = addr_r;
    wi_nxt        = wi_r;
    wj_nxt        = wj_r;
    rd_vld_nxt    = 1'b0;
    rd_pos_nxt    = addr_r;
    first_nxt     = first_r;
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    pdone_nxt     = pdone_r;
    sdone_nxt     = sdone_r;
    neg_nxt       = neg_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_pos_nxt   = out_pos_r;
    out_pd_nxt    = out_pd_r;
    out_sd_nxt    = out_sd_r;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    restart       = 1'b0;

    // Window element returned by the RAM
    if (rd_vld_r) begin
      if (mode_r == p2d_pkg::MODE_AVG) begin
        acc_nxt = acc_r + rd_ext;
      end else if (first_r || (rd_ext > acc_r)) begin
        acc_nxt = rd_ext;
        pos_nxt = rd_pos_r;
      end
      first_nxt = 1'b0;
    end

    case (state_r)
      p2d_pkg::S_IDLE: begin
        if (in_xfer) begin
          ram_we = 1'b1;
          if (close_r && close_c) begin
            addr_nxt  = idx_r - base_off;
            wi_nxt    = '0;
            wj_nxt    = '0;
            first_nxt = 1'b1;
            acc_nxt   = '0;
            pos_nxt   = '0;
            pdone_nxt = ((p2d_pkg::DIM_W+1)'(row_r) + (p2d_pkg::DIM_W+1)'(st_c)
                         >= (p2d_pkg::DIM_W+1)'(h_c))
                     && ((p2d_pkg::DIM_W+1)'(col_r) + (p2d_pkg::DIM_W+1)'(st_c)
                         >= (p2d_pkg::DIM_W+1)'(w_c));
            sdone_nxt = pdone_nxt && (nch >= ch_c);
            state_nxt = p2d_pkg::S_WALK;
          end
          // advance raster position and stride phases
          if (nc >= w_c) begin
            col_nxt = '0;
            cph_nxt = '0;
            if (nr >= h_c) begin
              row_nxt  = '0;
              rph_nxt  = '0;
              idx_nxt  = '0;
              chan_nxt = (nch >= ch_c) ? '0 : p2d_pkg::CHPOS_W'(nch);
            end else begin
              row_nxt = p2d_pkg::ROW_W'(nr);
              idx_nxt = idx_r + ADDR_W'(1);
              if (nr <= p2d_pkg::DIM_W'(ps_m1)) begin
                rph_nxt = '0;
              end else begin
                rph_nxt = (rph_r + p2d_pkg::STRIDE_W'(1) == st_c) ? '0
                        : rph_r + p2d_pkg::STRIDE_W'(1);
              end
            end
          end else begin
            col_nxt = p2d_pkg::COL_W'(nc);
            idx_nxt = idx_r + ADDR_W'(1);
            if (nc <= p2d_pkg::DIM_W'(ps_m1)) begin
              cph_nxt = '0;
            end else begin
              cph_nxt = (cph_r + p2d_pkg::STRIDE_W'(1) == st_c) ? '0
                      : cph_r + p2d_pkg::STRIDE_W'(1);
            end
          end
        end
      end
      p2d_pkg::S_WALK: begin
        rd_vld_nxt = 1'b1;
        if (wj_r == p2d_pkg::WIN_W'(ps_m1)) begin
          wj_nxt   = '0;
          wi_nxt   = wi_r + p2d_pkg::WIN_W'(1);
          addr_nxt = addr_r + ADDR_W'(w_c) - ADDR_W'(ps_m1);
        end else begin
          wj_nxt   = wj_r + p2d_pkg::WIN_W'(1);
          addr_nxt = addr_r + ADDR_W'(1);
        end
        if (last_iss) begin
          state_nxt = p2d_pkg::S_DRAIN;
        end
      end
      p2d_pkg::S_DRAIN: begin
        state_nxt = (mode_r == p2d_pkg::MODE_AVG) ? p2d_pkg::S_PREP : p2d_pkg::S_EMIT;
      end
      p2d_pkg::S_PREP: begin
        neg_nxt   = acc_r[SUM_W-1];
        quot_nxt  = acc_r[SUM_W-1] ? SUM_W'(-acc_r) : SUM_W'(acc_r);
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = p2d_pkg::S_DIV;
      end
      p2d_pkg::S_DIV: begin
        rem_nxt  = geq ? (sh - dvs) : sh;
        quot_nxt = {quot_r[SUM_W-2:0], geq};
        dcnt_nxt = dcnt_r + p2d_pkg::DCNT_W'(1);
        if (dcnt_r == p2d_pkg::DCNT_W'(SUM_W - 1)) begin
          acc_nxt   = neg_r ? -$signed(quot_nxt) : $signed(quot_nxt);
          state_nxt = p2d_pkg::S_EMIT;
        end
      end
      p2d_pkg::S_EMIT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = p2d_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = p2d_pkg::S_IDLE;
      end
    endcase

    if (out_load) begin
      out_vld_nxt = 1'b1;
      out_val_nxt = acc_r[SW-1:0];
      out_pos_nxt = p2d_pkg::POS_OUT_W'(pos_r);
      out_pd_nxt  = pdone_r;
      out_sd_nxt  = sdone_r;
    end

    if (cfg_xfer) begin
      case (cfg_ch.index)
        p2d_pkg::REG_WIN_SIDE: begin
          win_side_nxt = cfg_ch.data[p2d_pkg::POOL_W-1:0];
          restart      = 1'b1;
        end
        p2d_pkg::REG_STRIDE: begin
          stride_nxt = cfg_ch.data[p2d_pkg::STRIDE_W-1:0];
          restart    = 1'b1;
        end
        p2d_pkg::REG_PLANE_HEIGHT: begin
          height_nxt = cfg_ch.data[p2d_pkg::DIM_W-1:0];
          restart    = 1'b1;
        end
        p2d_pkg::REG_PLANE_WIDTH: begin
          width_nxt = cfg_ch.data[p2d_pkg::DIM_W-1:0];
          restart   = 1'b1;
        end
        p2d_pkg::REG_CHANNEL_COUNT: begin
          chans_nxt = cfg_ch.data[p2d_pkg::CHCNT_W-1:0];
          restart   = 1'b1;
        end
        p2d_pkg::REG_POOL_MODE: begin
          mode_nxt = cfg_ch.data[0];
          restart  = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end

    if (restart) begin
      row_nxt  = '0;
      col_nxt  = '0;
      chan_nxt = '0;
      idx_nxt  = '0;
      rph_nxt  = '0;
      cph_nxt  = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= p2d_pkg::S_IDLE;
      win_side_r  <= p2d_pkg::RST_WIN_SIDE;
      stride_r    <= p2d_pkg::RST_STRIDE;
      height_r    <= p2d_pkg::RST_HEIGHT;
      width_r     <= p2d_pkg::RST_WIDTH;
      chans_r     <= p2d_pkg::RST_CHANNELS;
      mode_r      <= p2d_pkg::RST_MODE;
      row_r       <= '0;
      col_r       <= '0;
      chan_r      <= '0;
      idx_r       <= '0;
      rph_r       <= '0;
      cph_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_side_r  <= win_side_nxt;
      stride_r    <= stride_nxt;
      height_r    <= height_nxt;
      width_r     <= width_nxt;
      chans_r     <= chans_nxt;
      mode_r      <= mode_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      chan_r      <= chan_nxt;
      idx_r       <= idx_nxt;
      rph_r       <= rph_nxt;
      cph_r       <= cph_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    wi_r      <= wi_nxt;
    wj_r      <= wj_nxt;
    rd_pos_r  <= rd_pos_nxt;
    first_r   <= first_nxt;
    acc_r     <= acc_nxt;
    pos_r     <= pos_nxt;
    pdone_r   <= pdone_nxt;
    sdone_r   <= sdone_nxt;
    neg_r     <= neg_nxt;
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    dcnt_r    <= dcnt_nxt;
    out_val_r <= out_val_nxt;
    out_pos_r <= out_pos_nxt;
    out_pd_r  <= out_pd_nxt;
    out_sd_r  <= out_sd_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/p2d_ram.sv =====
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
`default_nettype none

module p2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== bench/pool2d_max_average_tb.sv =====
// Self-checking bench for pool2d_max_average: random-idle sample driver, result monitor,
// and a window predictor that checks every pooled result field by field.
// Depends on p2d_pkg and the p2d_sample_if, p2d_result_if and p2d_cfg_if interfaces.
`timescale 1ns / 100ps

module pool2d_max_average_tb;

  localparam int CLK_PERIOD     = 10;
  localparam int MAX_CHANNELS   = 256;
  localparam int NUM_REGS       = 6;
  localparam int ITEM_TARGET    = 1950;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 400;
  localparam int TIMEOUT_CYCLES = 5000;

  localparam int SW    = p2d_pkg::SAMPLE_W;
  localparam int IDX_W = p2d_pkg::CFG_IDX_W;
  localparam int CFG_W = p2d_pkg::CFG_DATA_W;

  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [SW-1:0]    SAMPLE_MAX   = 16'h7FFF;
  localparam logic [SW-1:0]    SAMPLE_MIN   = 16'h8000;
  localparam logic [CFG_W-1:0] CFG_MODE_MAX = CFG_W'(p2d_pkg::MODE_MAX);
  localparam logic [CFG_W-1:0] CFG_MODE_AVG = CFG_W'(p2d_pkg::MODE_AVG);

  typedef struct {
    logic signed [SW-1:0]                 value;
    logic [p2d_pkg::POS_OUT_W-1:0]        position;
    logic                                 plane_end;
    logic                                 set_end;
  } pooled_t;

  logic clk = 1'b0;
  logic rst_n;

  p2d_sample_if in_ch();
  p2d_result_if out_ch();
  p2d_cfg_if    cfg_ch();

  pool2d_max_average dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // predictor state
  logic [p2d_pkg::POOL_W-1:0]   pool_reg   = p2d_pkg::RST_WIN_SIDE;
  logic [p2d_pkg::STRIDE_W-1:0] stride_reg = p2d_pkg::RST_STRIDE;
  logic [p2d_pkg::DIM_W-1:0]    height_reg = p2d_pkg::RST_HEIGHT;
  logic [p2d_pkg::DIM_W-1:0]    width_reg  = p2d_pkg::RST_WIDTH;
  logic [p2d_pkg::CHCNT_W-1:0]  chan_reg   = p2d_pkg::RST_CHANNELS;
  logic                         mode_reg   = p2d_pkg::RST_MODE;
  logic signed [SW-1:0]         plane_mem [p2d_pkg::STORE_DEPTH];
  int unsigned                  row_pos  = 0;
  int unsigned                  col_pos  = 0;
  int unsigned                  chan_pos = 0;

  logic signed [SW-1:0]       sample_backlog [$];
  pooled_t                    pooled_expected [$];
  pooled_t                    want;
  logic [CFG_W-1:0]           cfg_next [NUM_REGS];

  int          in_idle_pct  = 0;
  int          out_idle_pct = 0;
  int          in_gap       = 0;
  int          out_stall    = 0;
  int          hold_left    = 0;
  int          hold_requests = 0;
  int          hold_served  = 0;
  int          quiet_cycles = 0;
  int          errors       = 0;
  int unsigned samples_taken   = 0;
  int unsigned results_checked = 0;
  int unsigned regs_written    = 0;
  int unsigned random_settings = 0;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit closes_axis(int unsigned p, int unsigned len, int unsigned ps,
                                     int unsigned st);
    if (ps > len) return 1'b0;
    if (p + 1 < ps) return 1'b0;
    return ((p + 1 - ps) % st) == 0;
  endfunction

  function automatic int unsigned last_close(int unsigned len, int unsigned ps, int unsigned st);
    return ((len - ps) / st) * st + ps - 1;
  endfunction

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    case (idx)
      p2d_pkg::REG_WIN_SIDE:      pool_reg   = value[p2d_pkg::POOL_W-1:0];
      p2d_pkg::REG_STRIDE:        stride_reg = value[p2d_pkg::STRIDE_W-1:0];
      p2d_pkg::REG_PLANE_HEIGHT:  height_reg = value[p2d_pkg::DIM_W-1:0];
      p2d_pkg::REG_PLANE_WIDTH:   width_reg  = value[p2d_pkg::DIM_W-1:0];
      p2d_pkg::REG_CHANNEL_COUNT: chan_reg   = value[p2d_pkg::CHCNT_W-1:0];
      p2d_pkg::REG_POOL_MODE:     mode_reg   = value[0];
      default: return;
    endcase
    row_pos  = 0;
    col_pos  = 0;
    chan_pos = 0;
  endfunction

  // stores one sample and queues the pooled result it closes, if any
  function automatic void pool_window_predict(logic signed [SW-1:0] s);
    int unsigned ps, st, h, w, ch, r, c, r0, c0, idx, pos;
    int          value, sum;
    bit          first;
    pooled_t     res;
    ps = clamp_to(32'(pool_reg), p2d_pkg::MAX_POOL);
    st = clamp_to(32'(stride_reg), (1 << p2d_pkg::STRIDE_W) - 1);
    h  = clamp_to(32'(height_reg), p2d_pkg::MAX_HEIGHT);
    w  = clamp_to(32'(width_reg), p2d_pkg::MAX_WIDTH);
    ch = clamp_to(32'(chan_reg), MAX_CHANNELS);
    r  = (row_pos >= h) ? h - 1 : row_pos;
    c  = (col_pos >= w) ? w - 1 : col_pos;
    plane_mem[(r * w + c) % p2d_pkg::STORE_DEPTH] = s;
    if (closes_axis(r, h, ps, st) && closes_axis(c, w, ps, st)) begin
      r0 = r + 1 - ps;
      c0 = c + 1 - ps;
      value = 0;
      sum   = 0;
      pos   = 0;
      first = 1'b1;
      for (int unsigned i = r0; i <= r; i++) begin
        for (int unsigned j = c0; j <= c; j++) begin
          idx = (i * w + j) % p2d_pkg::STORE_DEPTH;
          sum += plane_mem[idx];
          if (first || plane_mem[idx] > value) begin
            value = plane_mem[idx];
            pos   = i * w + j;
            first = 1'b0;
          end
        end
      end
      if (mode_reg == p2d_pkg::MODE_AVG) begin
        value = sum / int'(ps * ps);
        pos   = 0;
      end
      res.value     = value[SW-1:0];
      res.position  = pos[p2d_pkg::POS_OUT_W-1:0];
      res.plane_end = (r == last_close(h, ps, st)) && (c == last_close(w, ps, st));
      res.set_end   = res.plane_end && (chan_pos + 1 >= ch);
      pooled_expected.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) begin
        r = 0;
        chan_pos++;
        if (chan_pos >= ch) chan_pos = 0;
      end
    end
    row_pos = r;
    col_pos = c;
  endfunction

  function automatic int draw_gap(int pct);
    return ($urandom_range(0, 99) < pct) ? int'($urandom_range(0, 16)) : 0;
  endfunction

  function automatic logic signed [SW-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return SW'($urandom_range(0, 4)) - 16'sd2;
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_field(int unsigned common_hi, int unsigned top,
                                             int unsigned field_max);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return top;
      2: return $urandom_range(top, field_max);
      default: return $urandom_range(1, common_hi);
    endcase
  endfunction

  function automatic void report_mismatch(string what, int exp_v, int got_v);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
  endfunction

  function automatic void pick_idle();
    int styles [3] = '{0, 30, 100};
    in_idle_pct  = styles[$urandom_range(0, 2)];
    out_idle_pct = styles[$urandom_range(0, 2)];
  endfunction

  // leaves valid high so back-to-back writes need no idle between them
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    apply_reg(idx, value);
    regs_written++;
  endtask

  task automatic program_regs(bit [NUM_REGS-1:0] mask, bit spare);
    bit any;
    any = 1'b0;
    for (int k = 0; k < NUM_REGS; k++) begin
      if (mask[k]) begin
        write_reg(IDX_W'(k), cfg_next[k]);
        any = 1'b1;
      end
    end
    if (spare) begin
      write_reg(REG_SPARE_LO + IDX_W'($urandom_range(0, 1)), CFG_W'($urandom));
      any = 1'b1;
    end
    if (any) cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] pool, stride, height, width, chans,
                          mode);
    cfg_next[p2d_pkg::REG_WIN_SIDE]      = pool;
    cfg_next[p2d_pkg::REG_STRIDE]        = stride;
    cfg_next[p2d_pkg::REG_PLANE_HEIGHT]  = height;
    cfg_next[p2d_pkg::REG_PLANE_WIDTH]   = width;
    cfg_next[p2d_pkg::REG_CHANNEL_COUNT] = chans;
    cfg_next[p2d_pkg::REG_POOL_MODE]     = mode;
    program_regs('1, 1'b0);
  endtask

  // also covers a result still in flight after the last expected one
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_backlog.size() != 0 || in_ch.valid || pooled_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic feed_random(int unsigned n);
    repeat (n) sample_backlog.push_back(draw_sample());
    wait_idle();
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pool_window_predict(in_ch.sample);
        samples_taken++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered sample
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (sample_backlog.size() != 0) begin
        in_ch.sample <= sample_backlog.pop_front();
        in_ch.valid  <= 1'b1;
        in_gap = draw_gap(in_idle_pct);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pooled_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got value %0d position %0d",
                   $time, out_ch.pooled_value, out_ch.max_position);
        end else begin
          want = pooled_expected.pop_front();
          if (out_ch.pooled_value !== want.value)
            report_mismatch("pooled_value", want.value, out_ch.pooled_value);
          if (out_ch.max_position !== want.position)
            report_mismatch("max_position", want.position, out_ch.max_position);
          if (out_ch.plane_done !== want.plane_end)
            report_mismatch("plane_done", want.plane_end, out_ch.plane_done);
          if (out_ch.set_done !== want.set_end)
            report_mismatch("set_done", want.set_end, out_ch.set_done);
        end
        results_checked++;
        out_stall = draw_gap(out_idle_pct);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_ch.ready <= (out_stall == 0) && (hold_left == 0);
    end
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= TIMEOUT_CYCLES) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("FAIL pool2d_max_average");
      $finish;
    end
  end

  initial begin
    int unsigned set_len, n;
    bit [NUM_REGS-1:0] mask;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, 28x28 with 2x2 windows: four equal minima, first one wins
    pick_idle();
    for (int k = 0; k < 30; k++)
      sample_backlog.push_back((k % 28 < 2) ? SAMPLE_MIN : draw_sample());
    wait_idle();

    // tie on the maximum across overlapping windows
    set_regs(2, 1, 2, 3, 1, CFG_MODE_MAX);
    sample_backlog = '{SAMPLE_MAX, SAMPLE_MAX, 16'sd0, SAMPLE_MAX, 16'sd1, 16'sd2};
    wait_idle();

    // average truncates toward zero; full-scale averages
    cfg_next[p2d_pkg::REG_POOL_MODE]     = CFG_MODE_AVG;
    cfg_next[p2d_pkg::REG_CHANNEL_COUNT] = 2;
    program_regs(NUM_REGS'((1 << p2d_pkg::REG_POOL_MODE) |
                           (1 << p2d_pkg::REG_CHANNEL_COUNT)), 1'b0);
    sample_backlog = '{-16'sd3, -16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                       SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX};
    wait_idle();

    // zero window, stride, height and channel count
    set_regs(0, 0, 0, 3, 0, CFG_MODE_MAX);
    feed_random(4);

    // window larger than the plane
    set_regs(3, 1, 2, 5, 1, CFG_MODE_MAX);
    feed_random(10);

    // unused register index mid-plane must not restart the plane
    set_regs(1, 1, 2, 2, 1, CFG_MODE_AVG);
    feed_random(2);
    program_regs('0, 1'b1);
    feed_random(2);

    // oversized window saturates to 8x8
    pick_idle();
    set_regs(9'h1F9, 8, 8, 8, 1, CFG_MODE_AVG);
    feed_random(64);
    cfg_next[p2d_pkg::REG_POOL_MODE] = CFG_MODE_MAX;
    program_regs(NUM_REGS'(1 << p2d_pkg::REG_POOL_MODE), 1'b0);
    feed_random(64);

    // height and width saturate to 64, widest stride
    pick_idle();
    set_regs(1, 1, 127, 1, 1, CFG_MODE_MAX);
    feed_random(65);
    set_regs(2, 15, 2, 100, 1, CFG_MODE_MAX);
    feed_random(128);

    // channel count saturates to 256; receiver holds off so the input backs up
    pick_idle();
    in_idle_pct = 0;
    hold_requests++;
    set_regs(1, 1, 1, 1, 9'h1FF, CFG_MODE_AVG);
    feed_random(260);

    while (samples_taken < ITEM_TARGET) begin
      pick_idle();
      mask = NUM_REGS'($urandom);
      cfg_next[p2d_pkg::REG_WIN_SIDE] =
        {5'($urandom), p2d_pkg::POOL_W'(pick_field(4, p2d_pkg::MAX_POOL, 15))};
      cfg_next[p2d_pkg::REG_STRIDE] =
        {5'($urandom), p2d_pkg::STRIDE_W'(pick_field(3, 8, 15))};
      cfg_next[p2d_pkg::REG_PLANE_HEIGHT] =
        {2'($urandom), p2d_pkg::DIM_W'(pick_field(8, p2d_pkg::MAX_HEIGHT, 127))};
      cfg_next[p2d_pkg::REG_PLANE_WIDTH] =
        {2'($urandom), p2d_pkg::DIM_W'(pick_field(8, p2d_pkg::MAX_WIDTH, 127))};
      cfg_next[p2d_pkg::REG_CHANNEL_COUNT] =
        p2d_pkg::CHCNT_W'(pick_field(3, MAX_CHANNELS, 511));
      cfg_next[p2d_pkg::REG_POOL_MODE] = CFG_W'($urandom);
      program_regs(mask, $urandom_range(0, 7) == 0);
      set_len = clamp_to(32'(height_reg), p2d_pkg::MAX_HEIGHT) *
                clamp_to(32'(width_reg), p2d_pkg::MAX_WIDTH) *
                clamp_to(32'(chan_reg), MAX_CHANNELS);
      n = (set_len <= 200) ? set_len * $urandom_range(1, 2) : $urandom_range(20, 150);
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      if (n > ITEM_TARGET - samples_taken) n = ITEM_TARGET - samples_taken;
      random_settings++;
      feed_random(n);
    end

    $display("Covered %0d samples, %0d pooled results and %0d register writes:", samples_taken,
             results_checked, regs_written);
    $display("reset and corner settings plus %0d random settings, max and average modes.",
             random_settings);
    if (errors == 0)
      $display("PASS pool2d_max_average");
    else
      $display("FAIL pool2d_max_average");
    $finish;
  end

endmodule
